@@ hdl/dpw_pkg.sv @@
// shared constants, types and register codes for the deformed periodic wrap
`default_nettype none
package dpw_pkg;

  localparam int POS_W          = 32;
  localparam int COEF_W         = 32;
  localparam int BOX_W          = 31;
  localparam int CFG_W          = 32;
  localparam int COEF_FRAC_BITS = 28;
  localparam int PIPE_DEPTH     = 5;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BOX_X   = 3'd0,
    REG_BOX_Y   = 3'd1,
    REG_BOX_Z   = 3'd2,
    REG_COEF_XX = 3'd3,
    REG_COEF_XZ = 3'd4,
    REG_COEF_ZZ = 3'd5
  } cfg_reg_t;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic        [BOX_W-1:0]  box_t;

  // fields that ride along the pipe next to the matrix work
  typedef struct packed {
    pos_t px;
    pos_t py;
    pos_t pz;
    logic en;
  } carry_t;

endpackage
`default_nettype wire

@@ hdl/deformed_periodic_wrap.sv @@
// top level: periodic wrap of one position in an extensionally deformed box
//
//   channel  ports                                   handshake
//   request  in_pos_x/y/z, in_deformed_enable        start & !busy
//   result   out_x/y/z, out_crossed                  out_valid, one cycle
//   config   cfg_idx, cfg_data                       cfg_we, no wait
//
// one request per cycle while busy is low, results come out in acceptance order
// the pipe is the two matrix passes (product stage + sum stage each)
// and the wrap stage between them
// busy is registered: set while reset is held, cleared once a clock edge sees reset released
// the receiver cannot stall, so the pipe never holds
`default_nettype none
module deformed_periodic_wrap (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [31:0]         in_pos_x,
  input  wire logic signed [31:0]         in_pos_y,
  input  wire logic signed [31:0]         in_pos_z,
  input  wire logic                       in_deformed_enable,
  output logic                            out_valid,
  output logic signed [31:0]              out_x,
  output logic signed [31:0]              out_y,
  output logic signed [31:0]              out_z,
  output logic                            out_crossed,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_idx,
  input  wire logic [dpw_pkg::CFG_W-1:0]  cfg_data
);
  import dpw_pkg::*;

  // configuration registers
  box_t  box_x_r, box_y_r, box_z_r;
  coef_t coef_xx_r, coef_xz_r, coef_zz_r;
  logic  busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r   <= '0;
      box_y_r   <= '0;
      box_z_r   <= '0;
      coef_xx_r <= COEF_ONE;
      coef_xz_r <= '0;
      coef_zz_r <= COEF_ONE;
      busy_r    <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_BOX_X:   box_x_r   <= cfg_data[BOX_W-1:0];
          REG_BOX_Y:   box_y_r   <= cfg_data[BOX_W-1:0];
          REG_BOX_Z:   box_z_r   <= cfg_data[BOX_W-1:0];
          REG_COEF_XX: coef_xx_r <= cfg_data[COEF_W-1:0];
          REG_COEF_XZ: coef_xz_r <= cfg_data[COEF_W-1:0];
          REG_COEF_ZZ: coef_zz_r <= cfg_data[COEF_W-1:0];
          default: ;  // unknown index, write dropped
        endcase
      end
    end
  end

  assign busy = busy_r;

  // single wrap toward [0, len); hit says a correction was applied
  function automatic pos_t wrap_once(input pos_t v, input box_t len, output logic hit);
    logic signed [POS_W:0] ve, le;
    begin
      ve = {v[POS_W-1], v};
      le = {2'b00, len};
      if (ve >= le) begin
        hit       = 1'b1;
        wrap_once = POS_W'(ve - le);
      end else if (v[POS_W-1]) begin
        hit       = 1'b1;
        wrap_once = POS_W'(ve + le);
      end else begin
        hit       = 1'b0;
        wrap_once = v;
      end
    end
  endfunction

  logic accept;
  assign accept = start && !busy_r;

  // valid bits, one per stage
  logic [PIPE_DEPTH:1] vld_r, vld_nxt;

  always_comb begin
    vld_nxt = {vld_r[PIPE_DEPTH-1:1], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // side band: original x/z, wrapped y and the enable travel alongside
  carry_t carry_r [1:PIPE_DEPTH];
  carry_t carry_nxt;
  logic   y_hit_unused;

  always_comb begin
    carry_nxt.px = in_pos_x;
    carry_nxt.pz = in_pos_z;
    carry_nxt.en = in_deformed_enable;
    carry_nxt.py = wrap_once(in_pos_y, box_y_r, y_hit_unused);
  end

  always_ff @(posedge clk) begin
    carry_r[1] <= carry_nxt;
    for (int i = 2; i <= PIPE_DEPTH; i++) begin
      carry_r[i] <= carry_r[i-1];
    end
  end

  // stages 1-2: into the undeformed frame with the inverse [zz, -xz; -xz, xx]
  pos_t sx, sz;

  dpw_xform u_inv (
    .clk     (clk),
    .c11     (coef_zz_r),
    .c22     (coef_xx_r),
    .c12     (coef_xz_r),
    .sub_off (1'b1),
    .u       (in_pos_x),
    .w       (in_pos_z),
    .o1      (sx),
    .o2      (sz)
  );

  // stage 3: wrap z then x once each
  pos_t sxw_r, szw_r, sxw_nxt, szw_nxt;
  logic hit3_r, hit3_nxt, hit_x, hit_z;
  logic hit4_r, hit5_r;

  always_comb begin
    szw_nxt  = wrap_once(sz, box_z_r, hit_z);
    sxw_nxt  = wrap_once(sx, box_x_r, hit_x);
    // a disabled request never reports a crossing
    hit3_nxt = carry_r[2].en && (hit_x || hit_z);
  end

  always_ff @(posedge clk) begin
    sxw_r  <= sxw_nxt;
    szw_r  <= szw_nxt;
    hit3_r <= hit3_nxt;
    hit4_r <= hit3_r;
    hit5_r <= hit4_r;
  end

  // stages 4-5: back to the deformed frame with [xx, xz; xz, zz]
  pos_t fx, fz;

  dpw_xform u_fwd (
    .clk     (clk),
    .c11     (coef_xx_r),
    .c22     (coef_zz_r),
    .c12     (coef_xz_r),
    .sub_off (1'b0),
    .u       (sxw_r),
    .w       (szw_r),
    .o1      (fx),
    .o2      (fz)
  );

  // no crossing or disabled: pass the original x/z bits untouched
  assign out_valid   = vld_r[PIPE_DEPTH];
  assign out_x       = hit5_r ? fx : carry_r[PIPE_DEPTH].px;
  assign out_z       = hit5_r ? fz : carry_r[PIPE_DEPTH].pz;
  assign out_y       = carry_r[PIPE_DEPTH].py;
  assign out_crossed = hit5_r;

  // each result must trace back to an accepted request
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without matching request");

  // a disabled request never reports a crossing
  a_disabled : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(in_deformed_enable, PIPE_DEPTH)) |-> !out_crossed)
    else $error("crossing flagged on disabled request");

  // without a crossing, x and z come back bit for bit
  a_passthru : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_crossed) |->
      (out_x == $past(in_pos_x, PIPE_DEPTH)) && (out_z == $past(in_pos_z, PIPE_DEPTH)))
    else $error("x/z altered without a crossing");

endmodule
`default_nettype wire

@@ hdl/dpw_xform.sv @@
// two-stage 2x2 symmetric matrix product: registered products, then floor and saturate
`default_nettype none
module dpw_xform (
  input  wire logic          clk,
  input  wire dpw_pkg::coef_t c11,
  input  wire dpw_pkg::coef_t c22,
  input  wire dpw_pkg::coef_t c12,
  input  wire logic          sub_off,
  input  wire dpw_pkg::pos_t  u,
  input  wire dpw_pkg::pos_t  w,
  output dpw_pkg::pos_t       o1,
  output dpw_pkg::pos_t       o2
);
  import dpw_pkg::*;

  localparam int PROD_W = POS_W + COEF_W;
  localparam int SUM_W  = PROD_W + 1;

  logic signed [PROD_W-1:0] p11_r, p12w_r, p12u_r, p22_r;
  logic                     sub_r;
  logic signed [SUM_W-1:0]  s1, s2;
  pos_t                     o1_r, o2_r, o1_nxt, o2_nxt;

  function automatic pos_t floor_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-COEF_FRAC_BITS-1:0] q;
    logic                                   fits;
    begin
      q    = s[SUM_W-1:COEF_FRAC_BITS];
      fits = (q[SUM_W-COEF_FRAC_BITS-1:POS_W-1] == '0) ||
             (q[SUM_W-COEF_FRAC_BITS-1:POS_W-1] == '1);
      if (fits) begin
        floor_sat = q[POS_W-1:0];
      end else if (q[SUM_W-COEF_FRAC_BITS-1]) begin
        floor_sat = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        floor_sat = {1'b0, {(POS_W-1){1'b1}}};
      end
    end
  endfunction

  // stage a: four products
  always_ff @(posedge clk) begin
    p11_r  <= c11 * u;
    p12w_r <= c12 * w;
    p12u_r <= c12 * u;
    p22_r  <= c22 * w;
    sub_r  <= sub_off;
  end

  // stage b: exact sums, floor by dropping fraction bits, clamp to 32 bits
  always_comb begin
    if (sub_r) begin
      s1 = SUM_W'(p11_r) - SUM_W'(p12w_r);
      s2 = SUM_W'(p22_r) - SUM_W'(p12u_r);
    end else begin
      s1 = SUM_W'(p11_r) + SUM_W'(p12w_r);
      s2 = SUM_W'(p22_r) + SUM_W'(p12u_r);
    end
    o1_nxt = floor_sat(s1);
    o2_nxt = floor_sat(s2);
  end

  always_ff @(posedge clk) begin
    o1_r <= o1_nxt;
    o2_r <= o2_nxt;
  end

  assign o1 = o1_r;
  assign o2 = o2_r;

endmodule
`default_nettype wire

@@ verif/dpw_wrap_checker.sv @@
`timescale 1ns / 100ps
// checker for the deformed periodic wrap: predicts each wrapped position and compares results
module dpw_wrap_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire logic signed [31:0]         in_pos_x,
  input  wire logic signed [31:0]         in_pos_y,
  input  wire logic signed [31:0]         in_pos_z,
  input  wire logic                       in_deformed_enable,
  input  wire logic                       out_valid,
  input  wire logic signed [31:0]         out_x,
  input  wire logic signed [31:0]         out_y,
  input  wire logic signed [31:0]         out_z,
  input  wire logic                       out_crossed,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_idx,
  input  wire logic [dpw_pkg::CFG_W-1:0]  cfg_data,
  output int                              mismatch_count,
  output int                              pending_results
);
  import dpw_pkg::*;

  // wide enough for two full products and their sum
  typedef logic signed [65:0] wide_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
    logic crossed;
  } wrapped_pos_t;

  box_t  box_x, box_y, box_z;
  coef_t cxx, cxz, czz;
  wrapped_pos_t wrapped_q[$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  function automatic pos_t saturate_pos(input wide_t v);
    if (v > wide_t'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (v < wide_t'(32'sh8000_0000)) return 32'sh8000_0000;
    return pos_t'(v);
  endfunction

  // one matrix row, floored back to Q16.16
  function automatic wide_t row_dot(input wide_t a1, input wide_t b1,
                                    input wide_t a2, input wide_t b2);
    wide_t acc;
    acc = a1 * b1 + a2 * b2;
    return acc >>> COEF_FRAC_BITS;
  endfunction

  function automatic wide_t fold_once(input wide_t v, input wide_t len, output bit did);
    did = 1'b1;
    if (v >= len) return v - len;
    if (v < 0) return v + len;
    did = 1'b0;
    return v;
  endfunction

  function automatic wrapped_pos_t wrap_position(input pos_t px, input pos_t py,
                                                 input pos_t pz, input logic en);
    wide_t sx, sz;
    bit hit, did;
    wrapped_pos_t r;
    r = '{x: px, y: py, z: pz, crossed: 1'b0};
    hit = 1'b0;
    if (en) begin
      // undeformed frame through the det-1 inverse
      sx = saturate_pos(row_dot(wide_t'(czz), wide_t'(px), -wide_t'(cxz), wide_t'(pz)));
      sz = saturate_pos(row_dot(-wide_t'(cxz), wide_t'(px), wide_t'(cxx), wide_t'(pz)));
      sz = fold_once(sz, wide_t'(box_z), did);
      hit = hit | did;
      sx = fold_once(sx, wide_t'(box_x), did);
      hit = hit | did;
      if (hit) begin
        r.x = saturate_pos(row_dot(wide_t'(cxx), sx, wide_t'(cxz), sz));
        r.z = saturate_pos(row_dot(wide_t'(cxz), sx, wide_t'(czz), sz));
      end
    end
    r.y = saturate_pos(fold_once(wide_t'(py), wide_t'(box_y), did));
    r.crossed = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    wrapped_pos_t want;
    if (!rst_n) begin
      box_x <= '0;
      box_y <= '0;
      box_z <= '0;
      cxx   <= COEF_ONE;
      cxz   <= '0;
      czz   <= COEF_ONE;
      wrapped_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_BOX_X:   box_x <= cfg_data[BOX_W-1:0];
          REG_BOX_Y:   box_y <= cfg_data[BOX_W-1:0];
          REG_BOX_Z:   box_z <= cfg_data[BOX_W-1:0];
          REG_COEF_XX: cxx   <= cfg_data;
          REG_COEF_XZ: cxz   <= cfg_data;
          REG_COEF_ZZ: czz   <= cfg_data;
          default: ;
        endcase
      end
      // check before queuing so a new request never answers itself
      if (out_valid) begin
        if (wrapped_q.size() == 0) begin
          $error("result with no request outstanding: x=%h y=%h z=%h crossed=%b",
                 out_x, out_y, out_z, out_crossed);
          mismatch_count++;
        end else begin
          want = wrapped_q.pop_front();
          if (out_x !== want.x) begin
            $error("out_x expected %h actual %h", want.x, out_x);
            mismatch_count++;
          end
          if (out_y !== want.y) begin
            $error("out_y expected %h actual %h", want.y, out_y);
            mismatch_count++;
          end
          if (out_z !== want.z) begin
            $error("out_z expected %h actual %h", want.z, out_z);
            mismatch_count++;
          end
          if (out_crossed !== want.crossed) begin
            $error("out_crossed expected %b actual %b", want.crossed, out_crossed);
            mismatch_count++;
          end
        end
      end
      if (start && !busy)
        wrapped_q.push_back(wrap_position(in_pos_x, in_pos_y, in_pos_z, in_deformed_enable));
    end
    pending_results = wrapped_q.size();
  end

endmodule

@@ verif/tb_deformed_periodic_wrap.sv @@
`timescale 1ns / 100ps
// testbench top: drives position requests and configuration register writes, gives the verdict
module tb_deformed_periodic_wrap;
  import dpw_pkg::*;

  localparam int POS_ONE         = 1 << 16;  // 1.0 in Q16.16
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_SETUP = 138;

  logic                clk;
  logic                rst_n              = 1'b0;
  logic                start              = 1'b0;
  logic                busy;
  pos_t                in_pos_x           = '0;
  pos_t                in_pos_y           = '0;
  pos_t                in_pos_z           = '0;
  logic                in_deformed_enable = 1'b0;
  logic                out_valid;
  pos_t                out_x, out_y, out_z;
  logic                out_crossed;
  logic                cfg_we             = 1'b0;
  logic [2:0]          cfg_idx            = '0;
  logic [CFG_W-1:0]    cfg_data           = '0;

  int mismatch_count;
  int pending_results;
  int idle_pct    = 16;  // chance in percent of a gap before each request
  int cycle_count = 0;
  int idle_pct_sched[3] = '{16, 62, 0};

  deformed_periodic_wrap dut (
    .clk, .rst_n, .start, .busy,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_deformed_enable,
    .out_valid, .out_x, .out_y, .out_z, .out_crossed,
    .cfg_we, .cfg_idx, .cfg_data
  );

  dpw_wrap_checker u_checker (
    .clk, .rst_n, .start, .busy,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_deformed_enable,
    .out_valid, .out_x, .out_y, .out_z, .out_crossed,
    .cfg_we, .cfg_idx, .cfg_data,
    .mismatch_count, .pending_results
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung pipe or lost result ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // all tasks start and end right after a falling edge
  task automatic cfg_write(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // full register set; the spare top bit of each box write must be ignored
  task automatic load_registers(input box_t lx, input box_t ly, input box_t lz,
                                input coef_t xx, input coef_t xz, input coef_t zz);
    cfg_write(REG_BOX_X, {1'($urandom), lx});
    cfg_write(REG_BOX_Y, {1'($urandom), ly});
    cfg_write(REG_BOX_Z, {1'($urandom), lz});
    cfg_write(REG_COEF_XX, xx);
    cfg_write(REG_COEF_XZ, xz);
    cfg_write(REG_COEF_ZZ, zz);
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(input pos_t x, input pos_t y, input pos_t z, input logic en);
    // random gap so idle cycles land on every pipe stage
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start              <= 1'b1;
    in_pos_x           <= x;
    in_pos_y           <= y;
    in_pos_z           <= z;
    in_deformed_enable <= en;
    // busy is stable between edges, so its value now holds at the coming edge
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // stop requesting and let every outstanding result come back
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (PIPE_DEPTH) @(negedge clk);
  endtask

  // coordinate near [0, len): mostly inside or within one length, some far or raw
  function automatic pos_t pick_coord(input box_t len);
    longint span, v;
    span = longint'(len);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = (span == 0) ? 0 : longint'($urandom) % span;
      4, 5:       v = -(longint'($urandom) % (span + 1)) - 1;
      6, 7:       v = span + longint'($urandom) % (span + 1);
      8:          v = $urandom_range(0, 1) ? 3 * span + longint'($urandom) % (span + 1)
                                           : -2 * span - longint'($urandom) % (span + 1);
      default:    v = longint'(pos_t'($urandom));
    endcase
    if (v > 64'sh7fff_ffff) v = 64'sh7fff_ffff;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return pos_t'(v);
  endfunction

  function automatic coef_t extreme_coef();
    case ($urandom_range(0, 4))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return COEF_ONE;
      default: return -COEF_ONE;
    endcase
  endfunction

  function automatic box_t extreme_box();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return box_t'(1);
      default: return 31'h7fff_ffff;
    endcase
  endfunction

  box_t  cur_box_x, cur_box_y, cur_box_z;

  // new register set: half the time a real extensional deformation, else raw or extreme
  task automatic random_registers();
    coef_t xx, xz, zz;
    case ($urandom_range(0, 3))
      0, 1: begin
        // stretch in [0.5, 2], compress by its inverse, small symmetric shear
        xx = $urandom_range(32'h0800_0000, 32'h2000_0000);
        zz = coef_t'((longint'(1) << (2 * COEF_FRAC_BITS)) / longint'(xx));
        xz = coef_t'(int'($urandom_range(0, 32'h0400_0000)) - int'(32'h0200_0000));
        if ($urandom_range(0, 1)) begin
          cur_box_x = box_t'($urandom_range(POS_ONE, 64 * POS_ONE));
          cur_box_y = box_t'($urandom_range(POS_ONE, 64 * POS_ONE));
          cur_box_z = box_t'($urandom_range(POS_ONE, 64 * POS_ONE));
        end else begin
          cur_box_x = box_t'($urandom_range(1, 32'h7fff_ffff));
          cur_box_y = box_t'($urandom_range(1, 32'h7fff_ffff));
          cur_box_z = box_t'($urandom_range(1, 32'h7fff_ffff));
        end
      end
      2: begin
        xx = $urandom;
        xz = $urandom;
        zz = $urandom;
        cur_box_x = box_t'($urandom);
        cur_box_y = box_t'($urandom);
        cur_box_z = box_t'($urandom);
      end
      default: begin
        xx = extreme_coef();
        xz = extreme_coef();
        zz = extreme_coef();
        cur_box_x = extreme_box();
        cur_box_y = extreme_box();
        cur_box_z = extreme_box();
      end
    endcase
    load_registers(cur_box_x, cur_box_y, cur_box_z, xx, xz, zz);
  endtask

  initial begin
    // synchronous reset held at the start, released right after a falling edge
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: zero boxes and identity matrix, so any coordinate >= 0 still
    // counts as a wrap by zero length
    send_request('0, '0, '0, 1'b1);
    send_request(-POS_ONE, -5, -7, 1'b1);
    send_request(5, 6, 7, 1'b0);
    drain_results();

    // stretch 2 along x, compress 0.5 along z: inside, each side, far outside
    load_registers(box_t'(10 * POS_ONE), box_t'(8 * POS_ONE), box_t'(12 * POS_ONE),
                   32'sh2000_0000, '0, 32'sh0800_0000);
    send_request(3 * POS_ONE, 2 * POS_ONE, 4 * POS_ONE, 1'b1);       // no wrap at all
    send_request(-POS_ONE, -POS_ONE, 4 * POS_ONE, 1'b1);             // x below the box
    send_request(50 * POS_ONE, 30 * POS_ONE, 4 * POS_ONE, 1'b1);     // far out, wrapped once
    send_request(3 * POS_ONE, 2 * POS_ONE, 7 * POS_ONE, 1'b1);       // z above the box
    send_request(20 * POS_ONE, 8 * POS_ONE, 3 * POS_ONE, 1'b1);      // exactly on the far wall
    send_request(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_request(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    send_request(50 * POS_ONE, -3 * POS_ONE, -40 * POS_ONE, 1'b0);   // wrap off, y only
    drain_results();

    // largest boxes and extreme coefficients: frame and mapped-back saturation
    load_registers(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                   32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000);
    send_request(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    send_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_request(32'sh1234_5678, 32'shedcb_a987, 32'sh0f0f_0f0f, 1'b1);
    send_request(1, -1, -1, 1'b1);
    drain_results();

    // one-lsb boxes with a shear; a write to a spare index must change nothing
    cfg_write(3'($urandom_range(6, 7)), $urandom);
    load_registers(box_t'(1), box_t'(1), box_t'(1), COEF_ONE, 32'sh1000_0000, 32'sh7fff_ffff);
    send_request('0, '0, '0, 1'b1);
    send_request(1, 1, 1, 1'b1);
    send_request(-1, -1, -1, 1'b1);
    send_request(32'sh0000_ffff, 32'shffff_0000, 32'sh5555_aaaa, 1'b1);
    drain_results();

    // random part: light sender gaps, then heavy, then back to back; each register
    // set is entered with the pipe empty
    foreach (idle_pct_sched[p]) begin
      idle_pct = idle_pct_sched[p];
      repeat (4) begin
        random_registers();
        repeat (ITEMS_PER_SETUP)
          send_request(pick_coord(cur_box_x), pick_coord(cur_box_y),
                       pick_coord(cur_box_z), $urandom_range(0, 9) != 0);
        drain_results();
      end
    end

    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
